[rtl/hrhp_pkg.sv]
package hrhp_pkg;

	localparam int unsigned LOCATION_LIMIT = 2319;
	localparam int unsigned LENGTH_DIGITS_LIMIT = 32;
	localparam int unsigned SHORT_HEAD = 12;
	localparam logic [47:0] LEN_MAX = 48'hFFFF_FFFF_FFFF;
	localparam logic [47:0] LEN_DIV10 = LEN_MAX / 48'd10;
	localparam logic [3:0] LEN_REM10 = 4'(LEN_MAX % 48'd10);

	localparam logic [7:0] CH_LF = 8'd10;
	localparam logic [7:0] CH_CR = 8'd13;
	localparam logic [7:0] CH_SP = 8'd32;
	localparam logic [7:0] CH_TAB = 8'd9;
	localparam logic [7:0] CH_COLON = 8'd58;

	typedef enum logic [2:0] {
		KIND_LOC_BYTE = 3'd0,
		KIND_LOC_COMMIT = 3'd1,
		KIND_LOC_DISCARD = 3'd2,
		KIND_DONE = 3'd3,
		KIND_ERROR = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ERR_STATUS = 2'd0,
		ERR_LENGTH = 2'd1,
		ERR_SHORT = 2'd2
	} err_t;

	typedef enum logic [10:0] {
		PH_IDLE = 11'b00000000001,
		PH_PREFIX = 11'b00000000010,
		PH_SEEK_SP = 11'b00000000100,
		PH_NUM = 11'b00000001000,
		PH_REST = 11'b00000010000,
		PH_NAME = 11'b00000100000,
		PH_VALUE_WS = 11'b00001000000,
		PH_VALUE = 11'b00010000000,
		PH_SKIP_LINE = 11'b00100000000,
		PH_LOC_OVER = 11'b01000000000,
		PH_STOPPED = 11'b10000000000
	} phase_t;

	// one queue entry between front and back
	typedef struct packed {
		logic [7:0] data;
		logic first;
	} beat_t;

	typedef struct packed {
		kind_t kind;
		logic [7:0] value_byte;
		logic [9:0] http_status;
		logic [47:0] body_length;
		logic length_present;
		logic is_chunked;
		logic location_present;
		logic [11:0] location_length;
		err_t error_code;
	} result_t;

	function automatic logic [7:0] to_lower(input logic [7:0] b);
		return (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
	endfunction

	function automatic logic [7:0] prefix_char(input logic [3:0] i);
		case (i)
			4'd0: return 8'h48;
			4'd1: return 8'h54;
			4'd2: return 8'h54;
			4'd3: return 8'h50;
			4'd4: return 8'h2F;
			4'd5: return 8'h31;
			4'd6: return 8'h2E;
			default: return 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] cl_char(input logic [4:0] i);
		case (i)
			5'd0: return "c";
			5'd1: return "o";
			5'd2: return "n";
			5'd3: return "t";
			5'd4: return "e";
			5'd5: return "n";
			5'd6: return "t";
			5'd7: return "-";
			5'd8: return "l";
			5'd9: return "e";
			5'd10: return "n";
			5'd11: return "g";
			5'd12: return "t";
			5'd13: return "h";
			default: return 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] te_char(input logic [4:0] i);
		case (i)
			5'd0: return "t";
			5'd1: return "r";
			5'd2: return "a";
			5'd3: return "n";
			5'd4: return "s";
			5'd5: return "f";
			5'd6: return "e";
			5'd7: return "r";
			5'd8: return "-";
			5'd9: return "e";
			5'd10: return "n";
			5'd11: return "c";
			5'd12: return "o";
			5'd13: return "d";
			5'd14: return "i";
			5'd15: return "n";
			5'd16: return "g";
			default: return 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] loc_char(input logic [4:0] i);
		case (i)
			5'd0: return "l";
			5'd1: return "o";
			5'd2: return "c";
			5'd3: return "a";
			5'd4: return "t";
			5'd5: return "i";
			5'd6: return "o";
			5'd7: return "n";
			default: return 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] chunked_char(input logic [11:0] i);
		case (i)
			12'd0: return "c";
			12'd1: return "h";
			12'd2: return "u";
			12'd3: return "n";
			12'd4: return "k";
			12'd5: return "e";
			12'd6: return "d";
			default: return 8'h00;
		endcase
	endfunction

endpackage

[rtl/hrhp_queue.sv]
module hrhp_queue (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input hrhp_pkg::beat_t in_beat,
	output logic out_valid,
	input logic out_ready,
	output hrhp_pkg::beat_t out_beat
);
	import hrhp_pkg::*;

	// two-entry fifo
	beat_t mem_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	logic push;
	logic pop;

	assign in_ready = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_beat = mem_q[rd_ptr_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= in_beat;
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q != 2'd3)
		else $error("queue count out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 2'd1)
		else $error("queue count missed a push");
	assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> count_q == $past(count_q) - 2'd1)
		else $error("queue count missed a pop");
endmodule

[rtl/hrhp_front.sv]
module hrhp_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] data_byte,
	input logic first_byte,
	output logic q_valid,
	input logic q_ready,
	output hrhp_pkg::beat_t q_beat
);
	import hrhp_pkg::*;

	// input skid register: takes a beat whenever it is empty or draining
	logic full_q;
	beat_t beat_q;

	assign in_ready = !full_q || q_ready;
	assign q_valid = full_q;
	assign q_beat = beat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (in_ready) begin
			full_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			beat_q.data <= data_byte;
			beat_q.first <= first_byte;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(full_q && !q_ready) |=> full_q && $stable(beat_q))
		else $error("front lost a stalled beat");
endmodule

[rtl/hrhp_back.sv]
module hrhp_back (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	output logic q_ready,
	input hrhp_pkg::beat_t q_beat,
	output logic out_valid,
	input logic out_ready,
	output hrhp_pkg::result_t out_res
);
	import hrhp_pkg::*;

	phase_t phase_q;
	logic [3:0] byte_count_q;
	logic [9:0] status_value_q;
	logic [1:0] status_digits_q;
	logic [4:0] name_index_q;
	logic [2:0] name_match_q;
	logic [11:0] value_length_q;
	logic [47:0] length_accum_q;
	logic length_flag_q;
	logic chunked_flag_q;
	logic location_flag_q;
	logic [11:0] committed_length_q;
	logic held_cr_q;

	logic ovalid_q;
	result_t ores_q;

	phase_t ph_n;
	logic [3:0] bc_n;
	logic [9:0] sv_n;
	logic [1:0] sd_n;
	logic [4:0] ni_n;
	logic [2:0] nm_n;
	logic [11:0] vl_n;
	logic [47:0] la_n;
	logic lf_n, cf_n, locf_n, hc_n;
	logic [11:0] cl_n;
	logic emit;
	result_t res;

	logic [7:0] b;
	logic [7:0] lb;
	logic is_digit;
	logic [3:0] dig;
	logic [3:0] idx;
	logic [11:0] loc_len;
	logic take;

	assign take = q_valid && q_ready;
	assign q_ready = !ovalid_q || out_ready;
	assign out_valid = ovalid_q;
	assign out_res = ores_q;

	assign b = q_beat.data;
	assign lb = to_lower(b);
	assign is_digit = (b >= 8'h30) && (b <= 8'h39);
	assign dig = 4'(b - 8'h30);
	assign loc_len = value_length_q - {11'd0, held_cr_q};

	always_comb begin
		logic go;
		phase_t ph0;
		logic [3:0] bc0;
		logic in_val;
		ph0 = q_beat.first ? PH_PREFIX : phase_q;
		bc0 = q_beat.first ? 4'd0 : byte_count_q;
		ph_n = ph0;
		bc_n = bc0;
		sv_n = q_beat.first ? 10'd0 : status_value_q;
		sd_n = q_beat.first ? 2'd0 : status_digits_q;
		ni_n = q_beat.first ? 5'd0 : name_index_q;
		nm_n = q_beat.first ? 3'b111 : name_match_q;
		vl_n = q_beat.first ? 12'd0 : value_length_q;
		la_n = q_beat.first ? 48'd0 : length_accum_q;
		lf_n = q_beat.first ? 1'b0 : length_flag_q;
		cf_n = q_beat.first ? 1'b0 : chunked_flag_q;
		locf_n = q_beat.first ? 1'b0 : location_flag_q;
		cl_n = q_beat.first ? 12'd0 : committed_length_q;
		hc_n = q_beat.first ? 1'b0 : held_cr_q;
		emit = 1'b0;
		res = '0;
		idx = bc0;
		in_val = 1'b0;
		go = !(ph0 == PH_IDLE || ph0 == PH_STOPPED);
		if (go && bc0 < 4'(SHORT_HEAD)) bc_n = bc0 + 4'd1;
		if (go) begin
			case (ph0)
				PH_PREFIX: begin
					if (idx >= 4'd7 || b != prefix_char(idx)) begin
						emit = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_STATUS;
						ph_n = PH_STOPPED;
					end else if (idx == 4'd6) begin
						ph_n = PH_SEEK_SP;
					end
				end
				PH_SEEK_SP: begin
					if (b == CH_SP) ph_n = PH_NUM;
					else if (b == CH_LF) begin
						emit = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_STATUS;
						ph_n = PH_STOPPED;
					end
				end
				PH_NUM: begin
					if (is_digit) begin
						sv_n = 10'(sv_n * 10'd10 + {6'd0, dig});
						sd_n = sd_n + 2'd1;
						if (sd_n == 2'd3) ph_n = PH_REST;
					end else if (!(sd_n == 2'd0 && (b == CH_SP || b == CH_TAB))) begin
						emit = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_STATUS;
						ph_n = PH_STOPPED;
					end
				end
				PH_REST, PH_SKIP_LINE: begin
					if (b == CH_LF) begin
						ph_n = PH_NAME; ni_n = 5'd0; nm_n = 3'b111; vl_n = 12'd0; hc_n = 1'b0;
					end
				end
				PH_NAME: begin
					if (b == CH_LF) begin
						if (ni_n == 5'd0 || (ni_n == 5'd1 && hc_n)) begin
							emit = 1'b1;
							ph_n = PH_STOPPED;
							// the head length counts this byte too
							if (bc_n < 4'(SHORT_HEAD)) begin
								res.kind = KIND_ERROR; res.error_code = ERR_SHORT;
							end else begin
								res.kind = KIND_DONE;
								res.http_status = sv_n;
								res.body_length = la_n;
								res.length_present = lf_n;
								res.is_chunked = cf_n;
								res.location_present = locf_n;
								res.location_length = locf_n ? cl_n : 12'd0;
							end
						end else begin
							ph_n = PH_NAME; ni_n = 5'd0; nm_n = 3'b111; vl_n = 12'd0;
							hc_n = 1'b0;
						end
					end else if (b == CH_COLON) begin
						if (ni_n == 5'd14 && nm_n[0]) nm_n = 3'b001;
						else if (ni_n == 5'd17 && nm_n[1]) nm_n = 3'b010;
						else if (ni_n == 5'd8 && nm_n[2]) nm_n = 3'b100;
						else nm_n = 3'b000;
						vl_n = 12'd0; hc_n = 1'b0;
						if (nm_n == 3'b001) la_n = 48'd0;
						ph_n = (nm_n != 3'b000) ? PH_VALUE_WS : PH_SKIP_LINE;
					end else begin
						if (!(ni_n < 5'd14 && lb == cl_char(ni_n))) nm_n[0] = 1'b0;
						if (!(ni_n < 5'd17 && lb == te_char(ni_n))) nm_n[1] = 1'b0;
						if (!(ni_n < 5'd8 && lb == loc_char(ni_n))) nm_n[2] = 1'b0;
						if (ni_n != 5'd31) ni_n = ni_n + 5'd1;
						hc_n = (b == CH_CR);
					end
				end
				PH_VALUE_WS: begin
					if (!(b == CH_SP || b == CH_TAB)) begin
						ph_n = PH_VALUE; in_val = 1'b1;
					end
				end
				PH_VALUE: in_val = 1'b1;
				PH_LOC_OVER: begin
					if (b == CH_LF) begin
						ph_n = PH_NAME; ni_n = 5'd0; nm_n = 3'b111; vl_n = 12'd0; hc_n = 1'b0;
						emit = 1'b1; res.kind = KIND_LOC_DISCARD;
					end
				end
				default: ph_n = PH_STOPPED;
			endcase
		end
		if (in_val) begin
			if (nm_n == 3'b001) begin
				if (b == CH_LF) begin
					if (vl_n == 12'd0) begin
						emit = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_LENGTH;
						ph_n = PH_STOPPED;
					end else begin
						lf_n = 1'b1;
						ph_n = PH_NAME; ni_n = 5'd0; nm_n = 3'b111; vl_n = 12'd0; hc_n = 1'b0;
					end
				end else if (hc_n || !is_digit) begin
					if (b == CH_CR && !hc_n) hc_n = 1'b1;
					else begin
						emit = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_LENGTH;
						ph_n = PH_STOPPED;
					end
				end else if (vl_n + 12'd1 >= 12'(LENGTH_DIGITS_LIMIT)) begin
					emit = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_LENGTH;
					ph_n = PH_STOPPED;
				end else begin
					vl_n = vl_n + 12'd1;
					// saturate when accum*10+d would pass the max
					if (la_n > LEN_DIV10 || (la_n == LEN_DIV10 && dig > LEN_REM10))
						la_n = LEN_MAX;
					else
						la_n = 48'((la_n << 3) + (la_n << 1) + {44'd0, dig});
				end
			end else if (nm_n == 3'b010) begin
				if (b == CH_LF) begin
					ph_n = PH_NAME; ni_n = 5'd0; nm_n = 3'b111; vl_n = 12'd0; hc_n = 1'b0;
				end else if (vl_n < 12'd7 && lb == chunked_char(vl_n)) begin
					vl_n = vl_n + 12'd1;
					if (vl_n == 12'd7) begin
						cf_n = 1'b1; ph_n = PH_SKIP_LINE;
					end
				end else begin
					ph_n = PH_SKIP_LINE;
				end
			end else begin
				if (b == CH_LF) begin
					ph_n = PH_NAME; ni_n = 5'd0; nm_n = 3'b111; vl_n = 12'd0; hc_n = 1'b0;
					emit = 1'b1;
					if (loc_len < 12'(LOCATION_LIMIT)) begin
						locf_n = 1'b1; cl_n = loc_len;
						res.kind = KIND_LOC_COMMIT; res.location_length = loc_len;
					end else begin
						res.kind = KIND_LOC_DISCARD;
					end
				end else if (vl_n >= 12'(LOCATION_LIMIT)) begin
					ph_n = PH_LOC_OVER;
				end else begin
					vl_n = vl_n + 12'd1;
					hc_n = (b == CH_CR);
					emit = 1'b1; res.kind = KIND_LOC_BYTE; res.value_byte = b;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			byte_count_q <= 4'd0;
			status_value_q <= 10'd0;
			status_digits_q <= 2'd0;
			name_index_q <= 5'd0;
			name_match_q <= 3'b111;
			value_length_q <= 12'd0;
			length_accum_q <= 48'd0;
			length_flag_q <= 1'b0;
			chunked_flag_q <= 1'b0;
			location_flag_q <= 1'b0;
			committed_length_q <= 12'd0;
			held_cr_q <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (take) ovalid_q <= emit;
			else if (out_ready) ovalid_q <= 1'b0;
			if (take) begin
				phase_q <= ph_n;
				byte_count_q <= bc_n;
				status_value_q <= sv_n;
				status_digits_q <= sd_n;
				name_index_q <= ni_n;
				name_match_q <= nm_n;
				value_length_q <= vl_n;
				length_accum_q <= la_n;
				length_flag_q <= lf_n;
				chunked_flag_q <= cf_n;
				location_flag_q <= locf_n;
				committed_length_q <= cl_n;
				held_cr_q <= hc_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) ores_q <= res;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && !out_ready) |=> ovalid_q && $stable(ores_q))
		else $error("result dropped while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		byte_count_q <= 4'(SHORT_HEAD))
		else $error("byte count past saturation");
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_VALUE || phase_q == PH_VALUE_WS) |-> $onehot(name_match_q))
		else $error("value phase without one recognized header");
endmodule

[rtl/http_response_head_parser.sv]
// channel  direction  handshake           payload
// in       input      in_valid/in_ready   data_byte, first_byte
// out      output     out_valid/out_ready kind, value_byte, http_status, body_length,
//                                         length_present, is_chunked, location_present,
//                                         location_length, error_code
// one beat per cycle sustained while out_ready stays high; a result is offered once its byte has passed
// the front register, the two-entry queue and the parse step into the output register
// the parse step is combinational: compares and one 48-bit shift-add
// arst_n clears all parse state; the block waits for a byte marked first_byte
// a stalled output holds its result; the queue and front register absorb the stall
module http_response_head_parser (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] data_byte,
	input logic first_byte,
	output logic out_valid,
	input logic out_ready,
	output logic [2:0] kind,
	output logic [7:0] value_byte,
	output logic [9:0] http_status,
	output logic [47:0] body_length,
	output logic length_present,
	output logic is_chunked,
	output logic location_present,
	output logic [11:0] location_length,
	output logic [1:0] error_code
);
	import hrhp_pkg::*;

	// front to queue
	logic f_valid, f_ready;
	beat_t f_beat;
	// queue to back
	logic b_valid, b_ready;
	beat_t b_beat;
	result_t res;

	hrhp_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.data_byte(data_byte), .first_byte(first_byte),
		.q_valid(f_valid), .q_ready(f_ready), .q_beat(f_beat)
	);

	hrhp_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.in_valid(f_valid), .in_ready(f_ready), .in_beat(f_beat),
		.out_valid(b_valid), .out_ready(b_ready), .out_beat(b_beat)
	);

	hrhp_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(b_valid), .q_ready(b_ready), .q_beat(b_beat),
		.out_valid(out_valid), .out_ready(out_ready), .out_res(res)
	);

	// unpack the result register onto the field ports
	assign kind = res.kind;
	assign value_byte = res.value_byte;
	assign http_status = res.http_status;
	assign body_length = res.body_length;
	assign length_present = res.length_present;
	assign is_chunked = res.is_chunked;
	assign location_present = res.location_present;
	assign location_length = res.location_length;
	assign error_code = res.error_code;
endmodule

[tb/tb_http_response_head_parser.sv]
`timescale 1ns / 100ps

module tb_http_response_head_parser;
	import hrhp_pkg::*;

	// parser phases mirrored in the testbench predictor
	typedef enum int {
		S_IDLE, S_PREFIX, S_SEEK_SP, S_NUM, S_REST, S_NAME,
		S_VALUE_WS, S_VALUE, S_SKIP_LINE, S_LOC_OVER, S_STOPPED
	} parse_phase_t;

	localparam logic [2:0] HIT_CL = 3'b001;
	localparam logic [2:0] HIT_TE = 3'b010;
	localparam logic [2:0] HIT_LOC = 3'b100;
	localparam int CYCLE_LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] data_byte = 8'd0;
	logic first_byte = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] kind;
	logic [7:0] value_byte;
	logic [9:0] http_status;
	logic [47:0] body_length;
	logic length_present;
	logic is_chunked;
	logic location_present;
	logic [11:0] location_length;
	logic [1:0] error_code;

	always #6 clk = ~clk;

	http_response_head_parser dut (.*);

	// beats waiting to be sent, and parse results still owed by the block
	beat_t send_q[$];
	result_t owed_q[$];
	int failures = 0;
	int cycles = 0;
	bit stim_done = 0;

	// predictor state
	parse_phase_t ph;
	int unsigned head_cnt, stat_val, stat_digits, nidx, vlen, commit_len;
	logic [2:0] hit;
	logic [47:0] cl_acc;
	bit cl_seen, chunked_seen, loc_seen, cr_held;

	function automatic logic [7:0] lc(input logic [7:0] b);
		return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
	endfunction

	function automatic void clear_parse();
		ph = S_IDLE; head_cnt = 0; stat_val = 0; stat_digits = 0; nidx = 0;
		hit = 3'b111; vlen = 0; cl_acc = '0; cl_seen = 0; chunked_seen = 0;
		loc_seen = 0; commit_len = 0; cr_held = 0;
	endfunction

	function automatic void start_line();
		ph = S_NAME; nidx = 0; hit = 3'b111; vlen = 0; cr_held = 0;
	endfunction

	function automatic void owe_error(input err_t code);
		result_t r;
		r = '0;
		r.kind = KIND_ERROR;
		r.error_code = code;
		ph = S_STOPPED;
		owed_q.push_back(r);
	endfunction

	function automatic void owe_plain(input kind_t k, input logic [7:0] vb,
			input logic [11:0] ll);
		result_t r;
		r = '0;
		r.kind = k;
		r.value_byte = vb;
		r.location_length = ll;
		owed_q.push_back(r);
	endfunction

	function automatic void value_byte_step(input logic [7:0] b);
		logic [7:0] ch_word[7];
		int unsigned d, keep;
		ch_word = '{"c", "h", "u", "n", "k", "e", "d"};
		if (hit == HIT_CL) begin
			if (b == CH_LF) begin
				if (vlen == 0) owe_error(ERR_LENGTH);
				else begin
					cl_seen = 1;
					start_line();
				end
			end else if (cr_held || b < "0" || b > "9") begin
				if (b == CH_CR && !cr_held) cr_held = 1;
				else owe_error(ERR_LENGTH);
			end else if (vlen + 1 >= LENGTH_DIGITS_LIMIT) begin
				owe_error(ERR_LENGTH);
			end else begin
				vlen++;
				d = b - "0";
				if (cl_acc > (LEN_MAX - 48'(d)) / 48'd10) cl_acc = LEN_MAX;
				else cl_acc = cl_acc * 48'd10 + 48'(d);
			end
		end else if (hit == HIT_TE) begin
			if (b == CH_LF) start_line();
			else if (vlen < 7 && lc(b) == ch_word[vlen]) begin
				vlen++;
				if (vlen == 7) begin
					chunked_seen = 1;
					ph = S_SKIP_LINE;
				end
			end else ph = S_SKIP_LINE;
		end else begin
			// location: stream, then commit or discard at end of line
			if (b == CH_LF) begin
				keep = vlen - (cr_held ? 1 : 0);
				start_line();
				if (keep < LOCATION_LIMIT) begin
					loc_seen = 1;
					commit_len = keep;
					owe_plain(KIND_LOC_COMMIT, 8'd0, 12'(keep));
				end else owe_plain(KIND_LOC_DISCARD, 8'd0, 12'd0);
			end else if (vlen >= LOCATION_LIMIT) begin
				ph = S_LOC_OVER;
			end else begin
				vlen++;
				cr_held = (b == CH_CR);
				owe_plain(KIND_LOC_BYTE, b, 12'd0);
			end
		end
	endfunction

	function automatic void predict_head_byte(input logic [7:0] b, input logic first);
		logic [7:0] pfx[7];
		int unsigned pos;
		logic [2:0] sel;
		result_t r;
		pfx = '{"H", "T", "T", "P", "/", "1", "."};
		if (first) begin
			clear_parse();
			ph = S_PREFIX;
		end
		if (ph == S_IDLE || ph == S_STOPPED) return;
		pos = head_cnt;
		if (head_cnt < SHORT_HEAD) head_cnt++;
		case (ph)
			S_PREFIX: begin
				if (pos >= 7 || b != pfx[pos]) owe_error(ERR_STATUS);
				else if (pos == 6) ph = S_SEEK_SP;
			end
			S_SEEK_SP: begin
				if (b == CH_SP) ph = S_NUM;
				else if (b == CH_LF) owe_error(ERR_STATUS);
			end
			S_NUM: begin
				if (b >= "0" && b <= "9") begin
					stat_val = (stat_val * 10 + (b - "0")) & 10'h3FF;
					stat_digits++;
					if (stat_digits >= 3) ph = S_REST;
				end else if (!(stat_digits == 0 && (b == CH_SP || b == CH_TAB)))
					owe_error(ERR_STATUS);
			end
			S_REST, S_SKIP_LINE: if (b == CH_LF) start_line();
			S_NAME: begin
				if (b == CH_LF) begin
					if (nidx == 0 || (nidx == 1 && cr_held)) begin
						// blank line ends the head
						if (head_cnt < SHORT_HEAD) owe_error(ERR_SHORT);
						else begin
							r = '0;
							r.kind = KIND_DONE;
							r.http_status = stat_val[9:0];
							r.body_length = cl_acc;
							r.length_present = cl_seen;
							r.is_chunked = chunked_seen;
							r.location_present = loc_seen;
							r.location_length = loc_seen ? 12'(commit_len) : 12'd0;
							ph = S_STOPPED;
							owed_q.push_back(r);
						end
					end else start_line();
				end else if (b == CH_COLON) begin
					sel = 3'b000;
					if (nidx == 14 && hit[0]) sel = HIT_CL;
					else if (nidx == 17 && hit[1]) sel = HIT_TE;
					else if (nidx == 8 && hit[2]) sel = HIT_LOC;
					hit = sel; vlen = 0; cr_held = 0;
					if (sel == HIT_CL) cl_acc = '0;
					ph = (sel != 0) ? S_VALUE_WS : S_SKIP_LINE;
				end else begin
					if (!(nidx < 14 && lc(b) == cl_char(5'(nidx)))) hit[0] = 1'b0;
					if (!(nidx < 17 && lc(b) == te_char(5'(nidx)))) hit[1] = 1'b0;
					if (!(nidx < 8 && lc(b) == loc_char(5'(nidx)))) hit[2] = 1'b0;
					if (nidx < 31) nidx++;
					cr_held = (b == CH_CR);
				end
			end
			S_VALUE_WS: begin
				if (!(b == CH_SP || b == CH_TAB)) begin
					ph = S_VALUE;
					value_byte_step(b);
				end
			end
			S_VALUE: value_byte_step(b);
			S_LOC_OVER: begin
				if (b == CH_LF) begin
					start_line();
					owe_plain(KIND_LOC_DISCARD, 8'd0, 12'd0);
				end
			end
			default: ph = S_STOPPED;
		endcase
	endfunction

	// stimulus helpers
	function automatic void push_text(input string s, input bit first_mark);
		beat_t bt;
		for (int i = 0; i < s.len(); i++) begin
			bt.data = s[i];
			bt.first = first_mark && (i == 0);
			send_q.push_back(bt);
		end
	endfunction

	function automatic string flip_case(input string s);
		string o;
		o = s;
		for (int i = 0; i < o.len(); i++)
			if ($urandom_range(0, 1) && o[i] >= "a" && o[i] <= "z") o[i] = o[i] - 8'd32;
		return o;
	endfunction

	function automatic string eol();
		return $urandom_range(0, 1) ? string'("\r\n") : string'("\n");
	endfunction

	function automatic string digits(input int n);
		string o;
		o = "";
		for (int i = 0; i < n; i++) o = {o, string'(8'("0" + $urandom_range(0, 9)))};
		return o;
	endfunction

	function automatic string junk(input int n);
		string o;
		logic [7:0] c;
		o = "";
		for (int i = 0; i < n; i++) begin
			c = 8'($urandom_range(0, 255));
			if (c == CH_LF || c == 8'd0) c = "x";
			o = {o, string'(c)};
		end
		return o;
	endfunction

	function automatic string loc_value(input int n);
		string o;
		o = "";
		for (int i = 0; i < n; i++)
			o = {o, string'(8'($urandom_range(0, 3) == 0 ? $urandom_range(128, 255)
				: $urandom_range(33, 126)))};
		return o;
	endfunction

	// one well formed head with random headers, sometimes corrupted
	function automatic void push_random_head();
		string h;
		int n, sel, pos;
		h = {"HTTP/1.", string'(8'($urandom_range(0, 1) ? "1" : "0")), " ",
			$urandom_range(0, 4) == 0 ? string'(" \t") : string'(""), digits(3),
			$urandom_range(0, 1) ? string'(" OK") : string'(""), eol()};
		n = $urandom_range(0, 5);
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(0, 9);
			case (sel)
				0, 1: h = {h, flip_case("content-length"), ": ",
					$urandom_range(0, 5) == 0 ? digits($urandom_range(15, 33))
					: digits($urandom_range(1, 6)), eol()};
				2: h = {h, flip_case("transfer-encoding"), ":",
					$urandom_range(0, 1) ? flip_case(" chunked") : " gzip", eol()};
				3, 4: h = {h, flip_case("location"), ": ",
					loc_value($urandom_range(0, 30)), eol()};
				5: h = {h, "content-lengthx: 5", eol()};
				6: h = {h, ": empty", eol()};
				7: h = {h, "no colon here", eol()};
				default: h = {h, "x-", junk($urandom_range(0, 12)), ": ", junk(4), eol()};
			endcase
		end
		h = {h, eol()};
		// corrupt some heads with a random byte
		if ($urandom_range(0, 5) == 0) begin
			pos = $urandom_range(0, h.len() - 1);
			h[pos] = 8'($urandom_range(1, 255));
		end
		push_text(h, 1);
		// trailing bytes after the head are ignored
		if ($urandom_range(0, 3) == 0) push_text(junk($urandom_range(1, 4)), 0);
	endfunction

	initial begin
		clear_parse();
		// bytes before any first byte are ignored
		push_text("xy", 0);
		push_text({"HTTP/1.1 200 OK\r\n", "Content-Length: 281474976710656\r\n",
			"Transfer-Encoding: Chunked\r\n", "LOCATION: /a\r\n", "\r\n"}, 1);
		push_text("HXTP", 1);
		push_text("HTTP/1.1\n", 1);
		push_text("HTTP/1.1 2x", 1);
		push_text("HTTP/1.1 \t2001 extra\nX\nconTent-length: 7\r\r\n", 1);
		push_text("HTTP/1.1 2\n", 1);
		push_text("HTTP/1.0 000\n\n", 1);
		push_text("HTTP/1.1 999 \ncontent-length:\n", 1);
		push_text("HTTP/1.1 999 \ncontent-length: 0000000000000000000000000000000\n", 1);
		push_text({"HTTP/1.1 301\nLocation: \xff\x00\r\n\r\n"}, 1);
		while (send_q.size() < 1850) push_random_head();
	end

	// driver: bursts of random length, random gaps between them
	int burst_left = 0, gap_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_ready) begin
				if (in_valid) void'(send_q.pop_front());
				if (send_q.size() == 0) begin
					in_valid <= 1'b0;
					stim_done <= 1;
				end else if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else begin
					in_valid <= 1'b1;
					data_byte <= send_q[0].data;
					first_byte <= send_q[0].first;
					if (burst_left == 0) begin
						burst_left <= $urandom_range(1, 40);
						gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
					end else burst_left <= burst_left - 1;
				end
			end
		end
	end

	// receiver stall pattern: alternates free-running and choppy stretches
	int stall_phase = 0;
	always @(posedge clk) begin
		stall_phase <= (stall_phase + 1) % 300;
		out_ready <= (stall_phase < 100) ? 1'b1 : ($urandom_range(0, 2) != 0);
	end

	// predictor feed and result check, both sampled at the edge
	always @(posedge clk) begin
		result_t want;
		cycles <= cycles + 1;
		if (arst_n && in_valid && in_ready) predict_head_byte(data_byte, first_byte);
		if (arst_n && out_valid && out_ready) begin
			if (owed_q.size() == 0) begin
				$error("unexpected result kind=%0d", kind);
				failures++;
			end else begin
				want = owed_q.pop_front();
				if (kind !== want.kind) begin
					$error("kind: expected %0d actual %0d", want.kind, kind); failures++;
				end
				if (value_byte !== want.value_byte) begin
					$error("value_byte: expected %0h actual %0h", want.value_byte, value_byte);
					failures++;
				end
				if (http_status !== want.http_status) begin
					$error("http_status: expected %0d actual %0d", want.http_status,
						http_status);
					failures++;
				end
				if (body_length !== want.body_length) begin
					$error("body_length: expected %0d actual %0d", want.body_length,
						body_length);
					failures++;
				end
				if (length_present !== want.length_present) begin
					$error("length_present: expected %0d actual %0d", want.length_present,
						length_present);
					failures++;
				end
				if (is_chunked !== want.is_chunked) begin
					$error("is_chunked: expected %0d actual %0d", want.is_chunked, is_chunked);
					failures++;
				end
				if (location_present !== want.location_present) begin
					$error("location_present: expected %0d actual %0d", want.location_present,
						location_present);
					failures++;
				end
				if (location_length !== want.location_length) begin
					$error("location_length: expected %0d actual %0d", want.location_length,
						location_length);
					failures++;
				end
				if (error_code !== want.error_code) begin
					$error("error_code: expected %0d actual %0d", want.error_code, error_code);
					failures++;
				end
			end
		end
	end

	// reset, then wait for drain with a tail for the pipeline latency
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		wait (stim_done && owed_q.size() == 0);
		repeat (20) @(posedge clk);
		if (failures == 0 && owed_q.size() == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end

	always @(posedge clk) begin
		if (cycles >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

endmodule

[sim.f]
rtl/hrhp_pkg.sv
rtl/hrhp_queue.sv
rtl/hrhp_front.sv
rtl/hrhp_back.sv
rtl/http_response_head_parser.sv
tb/tb_http_response_head_parser.sv
